// ===== src/htwd_pkg.sv =====
// Shared types and constants for the tree-walk decoder.
`default_nettype none
package htwd_pkg;

  localparam int IDX_W         = 9;
  localparam int SYM_W         = 8;
  localparam int KIND_W        = 2;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 32;
  localparam int BIT_CNT_W     = 4;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DECODE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_SYMBOL_TOTAL = 1'b0;
  localparam logic REG_ROOT_INDEX   = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic              is_leaf;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [BYTE_W-1:0] code_byte;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_item;
    logic             stream_done;
  } out_beat_t;

  typedef struct packed {
    logic             vld;
    out_beat_t        beat;
  } push_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    node_t            wdata;
    logic             rea;
    logic [IDX_W-1:0] raddr_a;
    logic             reb;
    logic [IDX_W-1:0] raddr_b;
  } ram_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_FLUSH
  } walk_state_t;

endpackage
`default_nettype wire

// ===== src/htwd_node_ram.sv =====
// Node table memory: one write port, two registered read ports.
`default_nettype none
module htwd_node_ram #(
  parameter int NODE_COUNT = 512
) (
  input  wire                clk,
  input  htwd_pkg::ram_req_t req,
  output htwd_pkg::node_t    q_a,
  output htwd_pkg::node_t    q_b
);

  localparam int          AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [31:0] DEPTH = 32'(NODE_COUNT);

  htwd_pkg::node_t mem [NODE_COUNT];
  htwd_pkg::node_t qa_r;
  htwd_pkg::node_t qb_r;
  logic            oob_a_r;
  logic            oob_b_r;
  logic            wr_ok;
  logic            ra_ok;
  logic            rb_ok;

  // Range checks: indexes past the table read as zero, writes there drop
  assign wr_ok = 32'(req.waddr) < DEPTH;
  assign ra_ok = 32'(req.raddr_a) < DEPTH;
  assign rb_ok = 32'(req.raddr_b) < DEPTH;

  // Write and read the table
  always_ff @(posedge clk) begin
    if (req.we && wr_ok) begin
      mem[AW'(req.waddr)] <= req.wdata;
    end
    if (req.rea) begin
      qa_r    <= mem[AW'(req.raddr_a)];
      oob_a_r <= !ra_ok;
    end
    if (req.reb) begin
      qb_r    <= mem[AW'(req.raddr_b)];
      oob_b_r <= !rb_ok;
    end
  end

  assign q_a = oob_a_r ? '0 : qa_r;
  assign q_b = oob_b_r ? '0 : qb_r;

endmodule
`default_nettype wire

// ===== src/htwd_walker.sv =====
// Bit-serial tree walk sequencer with code shift register and symbol holding stage.
`default_nettype none
module htwd_walker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  htwd_pkg::in_beat_t                 in_beat,
  output logic                               busy,
  input  wire [htwd_pkg::CNT_W-1:0]          symbol_total,
  input  wire [htwd_pkg::IDX_W-1:0]          root_index,
  input  wire                                out_free,
  output htwd_pkg::push_t                    push,
  output htwd_pkg::ram_req_t                 ram_req,
  input  htwd_pkg::node_t                    q_a,
  input  htwd_pkg::node_t                    q_b
);

  htwd_pkg::walk_state_t state_r, state_nxt;

  logic [htwd_pkg::BYTE_W-1:0]    sh_r, sh_nxt;
  logic [htwd_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic                           look_r, look_nxt;
  logic [htwd_pkg::IDX_W-1:0]     next_r, next_nxt;
  logic [htwd_pkg::IDX_W-1:0]     cur_node_r, cur_node_nxt;
  logic                           at_root_r, at_root_nxt;
  logic [htwd_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           pend_v_r, pend_v_nxt;
  htwd_pkg::out_beat_t            pend_r, pend_nxt;

  logic                           accept;
  logic                           adv;
  logic                           e1;
  logic                           e2;
  logic                           at_eff;
  logic [htwd_pkg::IDX_W-1:0]     node_eff;
  htwd_pkg::node_t                cur_ent;
  logic [htwd_pkg::CNT_W-1:0]     cnt_eff;
  logic                           bits_left;
  logic                           start;
  logic                           stop;
  logic                           issue;
  logic [htwd_pkg::IDX_W-1:0]     child;
  logic [htwd_pkg::BIT_CNT_W-1:0] bit_cnt_step;
  logic                           walk_fin;

  assign accept = in_valid && (state_r == htwd_pkg::ST_IDLE);
  assign busy   = (state_r != htwd_pkg::ST_IDLE);
  assign adv    = !pend_v_r || out_free;

  // Resolve last cycle's child lookup, then start the next bit
  always_comb begin
    e1        = look_r && q_b.leaf;
    at_eff    = look_r ? q_b.leaf : at_root_r;
    node_eff  = look_r ? (q_b.leaf ? root_index : next_r) : cur_node_r;
    cur_ent   = at_eff ? q_a : q_b;
    cnt_eff   = cnt_r + htwd_pkg::CNT_W'(e1);
    bits_left = (bit_cnt_r != htwd_pkg::BITS_PER_BYTE);
    // a leaf root right after a leaf hit would emit twice: hold that bit back
    start     = bits_left && !(e1 && q_a.leaf);
    stop      = start && (cnt_eff >= symbol_total);
    e2        = start && !stop && at_eff && cur_ent.leaf;
    issue     = start && !stop && !(at_eff && cur_ent.leaf);
    child     = sh_r[0] ? cur_ent.right : cur_ent.left;
    bit_cnt_step = bit_cnt_r + htwd_pkg::BIT_CNT_W'(start && !stop);
    walk_fin  = stop || (!issue && (bit_cnt_step == htwd_pkg::BITS_PER_BYTE));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      htwd_pkg::ST_IDLE: begin
        if (accept && (in_beat.kind == htwd_pkg::KIND_DECODE)) begin
          state_nxt = htwd_pkg::ST_BIT;
        end
      end
      htwd_pkg::ST_BIT: begin
        if (adv && walk_fin) begin
          state_nxt = htwd_pkg::ST_FLUSH;
        end
      end
      htwd_pkg::ST_FLUSH: begin
        if (adv) begin
          state_nxt = htwd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = htwd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    sh_nxt       = sh_r;
    bit_cnt_nxt  = bit_cnt_r;
    look_nxt     = look_r;
    next_nxt     = next_r;
    cur_node_nxt = cur_node_r;
    at_root_nxt  = at_root_r;
    cnt_nxt      = cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    push         = '0;
    ram_req      = '0;
    ram_req.waddr          = in_beat.node_index;
    ram_req.wdata.left     = in_beat.left_child;
    ram_req.wdata.right    = in_beat.right_child;
    ram_req.wdata.leaf     = in_beat.is_leaf;
    ram_req.wdata.sym      = in_beat.leaf_symbol;
    ram_req.raddr_a        = root_index;
    ram_req.raddr_b        = cur_node_r;
    case (state_r)
      htwd_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_beat.kind)
            htwd_pkg::KIND_LOAD: begin
              ram_req.we = 1'b1;
            end
            htwd_pkg::KIND_DECODE: begin
              // fetch root and current node entries
              ram_req.rea = 1'b1;
              ram_req.reb = 1'b1;
              sh_nxt      = in_beat.code_byte;
              bit_cnt_nxt = '0;
              look_nxt    = 1'b0;
            end
            htwd_pkg::KIND_RESTART: begin
              cur_node_nxt = '0;
              at_root_nxt  = 1'b1;
              cnt_nxt      = '0;
            end
            default: ;
          endcase
        end
      end
      htwd_pkg::ST_BIT: begin
        if (adv) begin
          cur_node_nxt = node_eff;
          at_root_nxt  = at_eff;
          cnt_nxt      = cnt_eff + htwd_pkg::CNT_W'(e2);
          look_nxt     = issue;
          next_nxt     = child;
          bit_cnt_nxt  = bit_cnt_step;
          ram_req.reb     = issue;
          ram_req.raddr_b = child;
          if (start && !stop) begin
            sh_nxt = {1'b0, sh_r[htwd_pkg::BYTE_W-1:1]};
          end
          // hold the new symbol, pass the older one on
          if (e1 || e2) begin
            if (pend_v_r) begin
              push.vld  = 1'b1;
              push.beat = pend_r;
            end
            pend_v_nxt            = 1'b1;
            pend_nxt.symbol       = e1 ? q_b.sym : cur_ent.sym;
            pend_nxt.last_of_item = 1'b0;
            pend_nxt.stream_done  = (htwd_pkg::CNT_W'(cnt_r + 32'd1) == symbol_total);
          end
        end
      end
      htwd_pkg::ST_FLUSH: begin
        if (pend_v_r && out_free) begin
          push.vld               = 1'b1;
          push.beat              = pend_r;
          push.beat.last_of_item = 1'b1;
          pend_v_nxt             = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= htwd_pkg::ST_IDLE;
      look_r     <= 1'b0;
      cur_node_r <= '0;
      at_root_r  <= 1'b1;
      cnt_r      <= '0;
      pend_v_r   <= 1'b0;
      bit_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      look_r     <= look_nxt;
      cur_node_r <= cur_node_nxt;
      at_root_r  <= at_root_nxt;
      cnt_r      <= cnt_nxt;
      pend_v_r   <= pend_v_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    next_r <= next_nxt;
    pend_r <= pend_nxt;
  end

endmodule
`default_nettype wire

// ===== src/huffman_tree_walk_decoder_unit.sv =====
// Top level of the Huffman tree-walk decoder: config registers, output register, walker, table.
//
// Input channel (in_valid / in_stall / in_data) takes one item per beat: node loads,
// code bytes and walk restarts. Result channel (out_valid / out_stall / out_data)
// carries one decoded symbol per beat, zero to eight beats per code byte, with
// last_of_item on the final symbol of a byte and stream_done when the count of
// symbols reaches symbol_total. The APB-style port holds symbol_total (address 0)
// and root_index (address 4); write it only while the block is idle.
// A code byte is accepted, then walked bit by bit: each bit's child read is registered
// in the table before the next bit uses it, so the last bit resolves once its read
// returns, and the final symbol is then released from the holding stage. A leaf root
// needs no child read, reaching symbol_total ends a byte early, and otherwise the
// dependent table read per bit paces the walk.
// A symbol leaves the holding stage when the next one is found or when the byte ends,
// so the first beat of a byte reaches out_valid through it and then the output register.
// While out_stall is high the walk pauses once the holding stage and the output
// register are both full; nothing is lost, and in_stall stays high until the byte is done.
// Reset clears the walk to the root, the symbol count and both registers; the node
// table is not cleared and must be loaded before decoding.
`default_nettype none
module huffman_tree_walk_decoder_unit #(
  parameter int NODE_COUNT = 512
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  htwd_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output htwd_pkg::out_beat_t                  out_data,
  input  wire                                  cfg_psel,
  input  wire                                  cfg_penable,
  input  wire                                  cfg_pwrite,
  input  wire [htwd_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire [htwd_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [htwd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  logic [htwd_pkg::CNT_W-1:0] symbol_total_r;
  logic [htwd_pkg::IDX_W-1:0] root_index_r;
  logic                       cfg_wr;
  logic                       out_valid_r;
  htwd_pkg::out_beat_t        out_data_r;
  logic                       out_free;
  htwd_pkg::push_t            push;
  htwd_pkg::ram_req_t         ram_req;
  htwd_pkg::node_t            q_a;
  htwd_pkg::node_t            q_b;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_total_r <= '0;
      root_index_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        htwd_pkg::REG_SYMBOL_TOTAL: symbol_total_r <= cfg_pwdata;
        htwd_pkg::REG_ROOT_INDEX:   root_index_r   <= cfg_pwdata[htwd_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      htwd_pkg::REG_SYMBOL_TOTAL: cfg_prdata = symbol_total_r;
      htwd_pkg::REG_ROOT_INDEX:   cfg_prdata = htwd_pkg::CFG_DATA_W'(root_index_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Output register: load on push, drop when taken
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      out_data_r <= push.beat;
    end
  end

  htwd_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_beat      (in_data),
    .busy         (in_stall),
    .symbol_total (symbol_total_r),
    .root_index   (root_index_r),
    .out_free     (out_free),
    .push         (push),
    .ram_req      (ram_req),
    .q_a          (q_a),
    .q_b          (q_b)
  );

  htwd_node_ram #(
    .NODE_COUNT (NODE_COUNT)
  ) u_node_ram (
    .clk (clk),
    .req (ram_req),
    .q_a (q_a),
    .q_b (q_b)
  );

endmodule
`default_nettype wire

// ===== bench/tb_huffman_tree_walk_decoder_unit.sv =====
// Self-checking testbench for the Huffman tree-walk decoder unit.
`timescale 1ns / 100ps
module tb_huffman_tree_walk_decoder_unit;

  localparam int NODES         = 512;
  localparam int RAND_DECODES  = 140;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_LEN      = 300;
  localparam int END_WAIT      = 20000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [htwd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  htwd_pkg::in_beat_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  htwd_pkg::out_beat_t             out_data;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [htwd_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [htwd_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [htwd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Shadow of the decoder state
  htwd_pkg::node_t     node_mem [NODES];
  bit                  node_ok [NODES];
  int                  written_idx [$];
  logic [8:0]          walk_node = '0;
  logic                walk_at_root = 1'b1;
  logic [31:0]         emitted_cnt = '0;
  logic [31:0]         total_reg = '0;
  logic [8:0]          root_reg = '0;
  htwd_pkg::out_beat_t pending_symbols [$];

  int errors = 0;
  int hold_cycles = 0;
  bit no_gaps = 1'b0;
  int cycle_count = 0;
  int n_decodes = 0;
  int n_loads = 0;
  int n_restarts = 0;
  int n_unused = 0;
  int n_beats = 0;
  int n_writes = 0;
  int n_rand_decodes = 0;

  huffman_tree_walk_decoder_unit dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Walk the shadow tree for one accepted item and queue the symbols it yields
  function automatic void predict_symbols(htwd_pkg::in_beat_t b);
    htwd_pkg::out_beat_t found [$];
    htwd_pkg::out_beat_t s;
    htwd_pkg::node_t     cur;
    htwd_pkg::node_t     nxt;
    logic [8:0]          here;
    logic [8:0]          hop;
    logic                emit;
    int                  i;
    s = '0;
    case (b.kind)
      htwd_pkg::KIND_LOAD: begin
        node_mem[b.node_index] = '{b.left_child, b.right_child, b.is_leaf, b.leaf_symbol};
        if (!node_ok[b.node_index]) begin
          node_ok[b.node_index] = 1'b1;
          written_idx.push_back(int'(b.node_index));
        end
      end
      htwd_pkg::KIND_RESTART: begin
        walk_node    = '0;
        walk_at_root = 1'b1;
        emitted_cnt  = '0;
      end
      htwd_pkg::KIND_DECODE: begin
        for (i = 0; i < 8; i++) begin
          if (emitted_cnt >= total_reg) break;
          here = walk_at_root ? root_reg : walk_node;
          cur  = node_mem[here];
          emit = 1'b0;
          if (walk_at_root && cur.leaf) begin
            // leaf root: emit and stay put
            emit     = 1'b1;
            s.symbol = cur.sym;
          end else begin
            hop = b.code_byte[i] ? cur.right : cur.left;
            nxt = node_mem[hop];
            if (nxt.leaf) begin
              emit         = 1'b1;
              s.symbol     = nxt.sym;
              walk_at_root = 1'b1;
              walk_node    = root_reg;
            end else begin
              walk_node    = hop;
              walk_at_root = 1'b0;
            end
          end
          if (emit) begin
            emitted_cnt    = emitted_cnt + 32'd1;
            s.last_of_item = 1'b0;
            s.stream_done  = (emitted_cnt == total_reg);
            found.push_back(s);
          end
        end
        if (found.size() > 0) found[found.size()-1].last_of_item = 1'b1;
        foreach (found[k]) pending_symbols.push_back(found[k]);
      end
      default: ;
    endcase
  endfunction

  // Pick a node that has already been loaded, so walks stay on loaded entries
  function automatic logic [8:0] pick_written();
    return 9'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic htwd_pkg::in_beat_t rand_beat(logic [htwd_pkg::KIND_W-1:0] k);
    logic [63:0]        raw;
    htwd_pkg::in_beat_t b;
    raw    = {$urandom, $urandom};
    b      = raw[$bits(htwd_pkg::in_beat_t)-1:0];
    b.kind = k;
    return b;
  endfunction

  function automatic htwd_pkg::in_beat_t decode_beat(logic [htwd_pkg::BYTE_W-1:0] code);
    htwd_pkg::in_beat_t b;
    b           = rand_beat(htwd_pkg::KIND_DECODE);
    b.code_byte = code;
    return b;
  endfunction

  // Offer one beat, hold it until accepted, then update the shadow state
  task automatic send_item(input htwd_pkg::in_beat_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_symbols(beat);
    case (beat.kind)
      htwd_pkg::KIND_LOAD:    n_loads++;
      htwd_pkg::KIND_DECODE:  n_decodes++;
      htwd_pkg::KIND_RESTART: n_restarts++;
      default:                n_unused++;
    endcase
  endtask

  task automatic load_node(input logic [8:0] idx, input logic [8:0] l, input logic [8:0] r,
                           input logic leaf, input logic [7:0] sym);
    htwd_pkg::in_beat_t b;
    b             = rand_beat(htwd_pkg::KIND_LOAD);
    b.node_index  = idx;
    b.left_child  = l;
    b.right_child = r;
    b.is_leaf     = leaf;
    b.leaf_symbol = sym;
    send_item(b);
  endtask

  // Drop valid, wait for every expected symbol, then let the walk settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (reg_idx == htwd_pkg::REG_SYMBOL_TOTAL) total_reg = value;
    else root_reg = value[8:0];
    n_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    want = (reg_idx == htwd_pkg::REG_SYMBOL_TOTAL) ? total_reg : {23'd0, root_reg};
    if (reg_idx == htwd_pkg::REG_ROOT_INDEX) readback = readback & 32'h1FF;
    if (readback !== want) begin
      errors++;
      $display("%0t: register %0d readback expected %h, got %h", $time, reg_idx, want,
               readback);
    end
  endtask

  // Load a random full binary tree with the given leaf count starting at base
  task automatic build_tree(input logic [8:0] base, input int leaves);
    int                 lft [64];
    int                 rgt [64];
    bit                 is_lf [64];
    int                 open_leaves [$];
    int                 used;
    int                 pick;
    int                 node;
    int                 j;
    htwd_pkg::in_beat_t b;
    used     = 1;
    is_lf[0] = 1'b1;
    open_leaves.push_back(0);
    while (open_leaves.size() < leaves) begin
      pick = $urandom_range(0, open_leaves.size() - 1);
      node = open_leaves[pick];
      open_leaves.delete(pick);
      is_lf[node]   = 1'b0;
      lft[node]     = used;
      rgt[node]     = used + 1;
      is_lf[used]   = 1'b1;
      is_lf[used+1] = 1'b1;
      open_leaves.push_back(used);
      open_leaves.push_back(used + 1);
      used += 2;
    end
    for (j = 0; j < used; j++) begin
      b            = rand_beat(htwd_pkg::KIND_LOAD);
      b.node_index = base + 9'(j);
      b.is_leaf    = is_lf[j];
      if (!is_lf[j]) begin
        b.left_child  = base + 9'(lft[j]);
        b.right_child = base + 9'(rgt[j]);
      end else begin
        // leaf children point at loaded nodes in case the leaf goes stale
        b.left_child  = pick_written();
        b.right_child = pick_written();
      end
      send_item(b);
    end
  endtask

  // Hand-built tree at root 0: plain walks, final-bit symbol, unused kind
  task automatic test_directed_walks();
    wait_idle();
    write_reg(htwd_pkg::REG_SYMBOL_TOTAL, 32'hFFFF_FFFF);
    write_reg(htwd_pkg::REG_ROOT_INDEX, 32'd0);
    load_node(9'd0, 9'd1, 9'd2, 1'b0, 8'h00);
    load_node(9'd1, 9'd0, 9'd0, 1'b1, 8'h00);
    load_node(9'd2, 9'd3, 9'd4, 1'b0, 8'h00);
    load_node(9'd3, 9'd511, 9'd511, 1'b1, 8'hFF);
    load_node(9'd4, 9'd0, 9'd0, 1'b1, 8'h5A);
    send_item(rand_beat(htwd_pkg::KIND_RESTART));
    send_item(decode_beat(8'h00));
    send_item(decode_beat(8'hFF));
    send_item(decode_beat(8'hA5));
    send_item(rand_beat(KIND_UNUSED));
    send_item(decode_beat(8'h40));
  endtask

  // Leaf at the root: one symbol per bit
  task automatic test_leaf_root();
    load_node(9'd511, 9'd511, 9'd0, 1'b1, 8'h81);
    wait_idle();
    write_reg(htwd_pkg::REG_ROOT_INDEX, 32'd511);
    send_item(decode_beat(8'hC3));
  endtask

  // Stop at the configured total, resume after restart, and a zero total
  task automatic test_symbol_total();
    wait_idle();
    write_reg(htwd_pkg::REG_ROOT_INDEX, 32'd0);
    write_reg(htwd_pkg::REG_SYMBOL_TOTAL, 32'd3);
    send_item(rand_beat(htwd_pkg::KIND_RESTART));
    send_item(decode_beat(8'h00));
    send_item(decode_beat(8'h00));
    send_item(rand_beat(htwd_pkg::KIND_RESTART));
    send_item(decode_beat(8'hFF));
    wait_idle();
    write_reg(htwd_pkg::REG_SYMBOL_TOTAL, 32'd0);
    send_item(rand_beat(htwd_pkg::KIND_RESTART));
    send_item(decode_beat(8'h5A));
  endtask

  // Turn an inner node into a leaf mid-walk, then move the root under a walk
  task automatic test_stale_leaf_and_root_change();
    wait_idle();
    write_reg(htwd_pkg::REG_SYMBOL_TOTAL, 32'hFFFF_FFFF);
    send_item(rand_beat(htwd_pkg::KIND_RESTART));
    send_item(decode_beat(8'h80));
    load_node(9'd2, 9'd3, 9'd4, 1'b1, 8'h77);
    send_item(decode_beat(8'h01));
    wait_idle();
    write_reg(htwd_pkg::REG_ROOT_INDEX, 32'd511);
    send_item(decode_beat(8'h00));
  endtask

  // Hold the output for a long stretch while bytes keep coming
  task automatic test_output_hold();
    logic [8:0] base;
    int         k;
    wait_idle();
    write_reg(htwd_pkg::REG_SYMBOL_TOTAL, 32'hFFFF_FFFF);
    base = 9'($urandom_range(0, 511));
    write_reg(htwd_pkg::REG_ROOT_INDEX, {23'd0, base});
    build_tree(base, 2);
    send_item(rand_beat(htwd_pkg::KIND_RESTART));
    no_gaps     = 1'b1;
    hold_cycles = HOLD_LEN;
    for (k = 0; k < 12; k++) send_item(decode_beat(8'($urandom)));
    no_gaps = 1'b0;
  endtask

  // One phase: new settings, a fresh tree, then mostly code bytes with some noise
  task automatic random_phase();
    logic [8:0]         base;
    bit                 do_build;
    int                 leaves;
    int                 items;
    int                 r;
    int                 k;
    htwd_pkg::in_beat_t b;
    wait_idle();
    no_gaps = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 9);
    if (r == 0) write_reg(htwd_pkg::REG_SYMBOL_TOTAL, 32'd0);
    else if (r < 4) write_reg(htwd_pkg::REG_SYMBOL_TOTAL, $urandom_range(1, 40));
    else if (r == 4) write_reg(htwd_pkg::REG_SYMBOL_TOTAL, $urandom);
    else write_reg(htwd_pkg::REG_SYMBOL_TOTAL, 32'hFFFF_FFFF);
    // without a fresh tree, reuse a loaded node as the root
    do_build = ($urandom_range(0, 7) != 0);
    base = do_build ? 9'($urandom_range(0, 511)) : pick_written();
    write_reg(htwd_pkg::REG_ROOT_INDEX, {23'd0, base});
    if (do_build) begin
      r = $urandom_range(0, 9);
      if (r == 0) leaves = 1;
      else if (r == 1) leaves = $urandom_range(17, 32);
      else leaves = $urandom_range(2, 8);
      build_tree(base, leaves);
    end
    send_item(rand_beat(htwd_pkg::KIND_RESTART));
    items = $urandom_range(12, 30);
    for (k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_item(decode_beat(8'($urandom)));
        n_rand_decodes++;
      end else if (r < 89) begin
        send_item(rand_beat(htwd_pkg::KIND_RESTART));
      end else if (r < 92) begin
        send_item(rand_beat(KIND_UNUSED));
      end else begin
        // rewrite a node, at times one of the eight entries from the base up, linked to loaded nodes
        b             = rand_beat(htwd_pkg::KIND_LOAD);
        b.left_child  = pick_written();
        b.right_child = pick_written();
        if (r < 96) b.node_index = base + 9'($urandom_range(0, 7));
        send_item(b);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_trees();
    while (n_rand_decodes < RAND_DECODES) random_phase();
  endtask

  // Compare one accepted symbol beat with the oldest expectation
  task automatic check_symbol(input htwd_pkg::out_beat_t got);
    htwd_pkg::out_beat_t want;
    if (pending_symbols.size() == 0) begin
      errors++;
      $display("%0t: unexpected symbol beat, expected none, got %h", $time, got);
    end else begin
      want = pending_symbols.pop_front();
      n_beats++;
      if (got.symbol !== want.symbol) begin
        errors++;
        $display("%0t: symbol expected %h, got %h", $time, want.symbol, got.symbol);
      end
      if (got.last_of_item !== want.last_of_item) begin
        errors++;
        $display("%0t: last_of_item expected %b, got %b", $time, want.last_of_item,
                 got.last_of_item);
      end
      if (got.stream_done !== want.stream_done) begin
        errors++;
        $display("%0t: stream_done expected %b, got %b", $time, want.stream_done,
                 got.stream_done);
      end
    end
  endtask

  // Result side: check each beat and drive random stall runs
  initial begin : symbol_sink
    int keep;
    int r;
    keep = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) check_symbol(out_data);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
        keep = 0;
      end else if (keep > 0) begin
        keep--;
      end else if (no_gaps) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          keep = $urandom_range(0, 7);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          keep = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          keep = $urandom_range(8, 30);
        end
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : test_sequence
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_walks();
    test_leaf_root();
    test_symbol_total();
    test_stale_leaf_and_root_change();
    test_output_hold();
    test_random_trees();

    // Drain what is left, with a bound
    in_valid <= 1'b0;
    waited = 0;
    while (pending_symbols.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_symbols.size() != 0) begin
      errors++;
      $display("%0t: %0d expected symbol beats, got none", $time, pending_symbols.size());
    end

    $display("Run: %0d code bytes, %0d node loads, %0d restarts, %0d unused-kind beats",
             n_decodes, n_loads, n_restarts, n_unused);
    $display("Run: %0d symbol beats checked over %0d register writes, %0d errors",
             n_beats, n_writes, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
